// ----- design/lzvn_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzvn_pkg
// Shared constants, opcode codes and controller/datapath types for the
// LZVN payload decoder.
// ----------------------------------------------------------------------------
package lzvn_pkg;

  localparam int WindowDepthDefault    = 65536;
  localparam int BytesPerResultDefault = 8;

  localparam logic [1:0] ST_DATA     = 2'd0;
  localparam logic [1:0] ST_EOS      = 2'd1;
  localparam logic [1:0] ST_UNDEF    = 2'd2;
  localparam logic [1:0] ST_BAD_DIST = 2'd3;

  localparam logic [7:0] OP_EOS    = 8'h06;
  localparam logic [7:0] OP_NOP_A  = 8'h0E;
  localparam logic [7:0] OP_NOP_B  = 8'h16;
  localparam logic [7:0] OP_UND_A  = 8'h1E;
  localparam logic [7:0] OP_UND_B  = 8'h26;
  localparam logic [7:0] OP_UND_C  = 8'h2E;
  localparam logic [7:0] OP_UND_D  = 8'h36;
  localparam logic [7:0] OP_UND_E  = 8'h3E;
  localparam logic [7:0] OP_LRG_L  = 8'hE0;
  localparam logic [7:0] OP_LRG_M  = 8'hF0;
  localparam logic [3:0] HI_UND_A  = 4'h7;
  localparam logic [3:0] HI_UND_B  = 4'hD;
  localparam logic [3:0] HI_SML_M  = 4'hF;
  localparam logic [2:0] TOP_SML_L = 3'b111;
  localparam logic [2:0] TOP_MED_D = 3'b101;
  localparam logic [2:0] LOW_PRE_D = 3'b110;
  localparam logic [2:0] LOW_LRG_D = 3'b111;
  localparam logic [2:0] EOS_PAD   = 3'd7;
  localparam logic [8:0] LRG_BIAS  = 9'd16;
  localparam logic [4:0] MATCH_MIN = 5'd3;

  typedef enum logic [2:0] {
    PH_OPCODE,
    PH_OPER1,
    PH_OPER2,
    PH_LIT,
    PH_PAD,
    PH_HALT
  } phase_t;

  typedef struct packed {
    logic load;
    logic parse;
    logic rd;
    logic cp;
    logic emit_pack;
    logic emit_last;
    logic emit_stat;
  } lzvn_cmd_t;

  typedef struct packed {
    logic go_match;
    logic pack_full;
    logic pack_nz;
    logic stat_nz;
    logic out_free;
    logic match_one;
  } lzvn_sts_t;

endpackage

// ----- design/lzvn_payload_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzvn_payload_if
// Compressed byte channel with valid/ready handshake.
// ----------------------------------------------------------------------------
interface lzvn_payload_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       new_block;

  modport source(output valid, output in_byte, output new_block, input ready);
  modport sink(input valid, input in_byte, input new_block, output ready);
endinterface

// ----- design/lzvn_result_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzvn_result_if
// Decoded result channel with valid/ready handshake.
// ----------------------------------------------------------------------------
interface lzvn_result_if;
  logic        valid;
  logic        ready;
  logic [63:0] out_bytes;
  logic [3:0]  byte_count;
  logic        last;
  logic [1:0]  status;

  modport source(output valid, output out_bytes, output byte_count, output last,
                 output status, input ready);
  modport sink(input valid, input out_bytes, input byte_count, input last,
               input status, output ready);
endinterface

// ----- design/lzvn_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzvn_ctrl
// Sequencer: accepts a byte, parses it, runs the match copy loop and
// flushes packed data and status results.
// ----------------------------------------------------------------------------
module lzvn_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  lzvn_pkg::lzvn_sts_t sts,
  output lzvn_pkg::lzvn_cmd_t cmd
);
  import lzvn_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PARSE,
    S_MREAD,
    S_MWRITE,
    S_FLUSH,
    S_STAT
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE:   if (in_valid) state <= S_PARSE;
        S_PARSE:  state <= sts.go_match ? S_MREAD : S_FLUSH;
        S_MREAD:  if (!sts.pack_full || sts.out_free) state <= S_MWRITE;
        S_MWRITE: state <= sts.match_one ? S_FLUSH : S_MREAD;
        S_FLUSH:  if (!sts.pack_nz || sts.out_free) state <= S_STAT;
        S_STAT:   if (!sts.stat_nz || sts.out_free) state <= S_IDLE;
        default:  state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_PARSE: cmd.parse = 1'b1;
      S_MREAD: begin
        if (!sts.pack_full || sts.out_free) begin
          cmd.rd        = 1'b1;
          cmd.emit_pack = sts.pack_full;
        end
      end
      S_MWRITE: cmd.cp = 1'b1;
      S_FLUSH: begin
        cmd.emit_pack = sts.pack_nz && sts.out_free;
        cmd.emit_last = !sts.stat_nz;
      end
      S_STAT: cmd.emit_stat = sts.stat_nz && sts.out_free;
      default: ;
    endcase
  end

endmodule

// ----- design/lzvn_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzvn_datapath
// Opcode parser state, history window, match address logic, result
// packer and output register.
// ----------------------------------------------------------------------------
module lzvn_datapath #(
  parameter int WINDOW_DEPTH     = lzvn_pkg::WindowDepthDefault,
  parameter int BYTES_PER_RESULT = lzvn_pkg::BytesPerResultDefault
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [7:0]          in_byte,
  input  logic                new_block,
  input  lzvn_pkg::lzvn_cmd_t cmd,
  output lzvn_pkg::lzvn_sts_t sts,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [63:0]         out_bytes,
  output logic [3:0]          byte_count,
  output logic                last,
  output logic [1:0]          status
);
  import lzvn_pkg::*;

  localparam int AW  = $clog2(WINDOW_DEPTH);
  localparam int BWW = $clog2(WINDOW_DEPTH + 1);
  localparam int NW  = $clog2(BYTES_PER_RESULT + 1);
  localparam int CW  = (BYTES_PER_RESULT > 1) ? $clog2(BYTES_PER_RESULT) : 1;

  logic [7:0]     hist [WINDOW_DEPTH];
  logic [7:0]     rdata;
  logic [7:0]     byte_q;
  logic           blk_q;
  phase_t         phase;
  logic [AW-1:0]  wp;
  logic [BWW-1:0] bw;
  logic [15:0]    match_dist;
  logic [7:0]     hop;
  logic [7:0]     hoper;
  logic [8:0]     lits;
  logic [8:0]     mlen;
  logic [2:0]     pad;
  logic [1:0]     stat_code;
  logic [7:0]     pack [BYTES_PER_RESULT];
  logic [NW-1:0]  cnt;

  phase_t         e_phase, n_phase;
  logic [AW-1:0]  e_wp;
  logic [BWW-1:0] e_bw, bw_after;
  logic [15:0]    e_dist, n_dist;
  logic [7:0]     e_hop, n_hop, e_hoper, n_hoper;
  logic [8:0]     e_lits, n_lits, e_mlen, n_mlen;
  logic [2:0]     e_pad, n_pad;
  logic [1:0]     n_stat;
  logic           n_go, put, do_begin, do_run;
  logic [8:0]     bl, bm;
  logic [3:0]     hi;
  logic [17:0]    wp18, d18, src18;
  logic [AW-1:0]  raddr, wp_inc, waddr;
  logic [7:0]     wdata;
  logic           we;
  logic [63:0]    packed_bytes;

  always_comb begin
    e_phase = blk_q ? PH_OPCODE : phase;
    e_wp    = blk_q ? '0 : wp;
    e_bw    = blk_q ? '0 : bw;
    e_dist  = blk_q ? '0 : match_dist;
    e_hop   = blk_q ? '0 : hop;
    e_hoper = blk_q ? '0 : hoper;
    e_lits  = blk_q ? '0 : lits;
    e_mlen  = blk_q ? '0 : mlen;
    e_pad   = blk_q ? '0 : pad;
    n_phase = e_phase;
    n_dist  = e_dist;
    n_hop   = e_hop;
    n_hoper = e_hoper;
    n_lits  = e_lits;
    n_mlen  = e_mlen;
    n_pad   = e_pad;
    n_stat  = ST_DATA;
    n_go    = 1'b0;
    put     = 1'b0;
    do_begin = 1'b0;
    do_run  = 1'b0;
    bl      = '0;
    bm      = '0;
    hi      = byte_q[7:4];
    unique case (e_phase)
      PH_OPCODE: begin
        if (byte_q == OP_EOS) begin
          n_stat  = ST_EOS;
          n_pad   = EOS_PAD;
          n_phase = PH_PAD;
        end else if (byte_q == OP_NOP_A || byte_q == OP_NOP_B) begin
          n_phase = e_phase;
        end else if (byte_q == OP_UND_A || byte_q == OP_UND_B || byte_q == OP_UND_C ||
                     byte_q == OP_UND_D || byte_q == OP_UND_E || hi == HI_UND_A ||
                     hi == HI_UND_B) begin
          n_stat  = ST_UNDEF;
          n_phase = PH_HALT;
        end else if (byte_q == OP_LRG_L || byte_q == OP_LRG_M) begin
          n_hop   = byte_q;
          n_phase = PH_OPER1;
        end else if (hi == HI_SML_M) begin
          do_begin = 1'b1;
          bm       = {5'd0, byte_q[3:0]};
        end else if (byte_q[7:5] == TOP_SML_L) begin
          do_begin = 1'b1;
          bl       = {5'd0, byte_q[3:0]};
        end else if (byte_q[2:0] == LOW_PRE_D && byte_q[7:5] != TOP_MED_D) begin
          do_begin = 1'b1;
          bl       = {7'd0, byte_q[7:6]};
          bm       = {6'd0, byte_q[5:3]} + {4'd0, MATCH_MIN};
        end else begin
          n_hop   = byte_q;
          n_phase = PH_OPER1;
        end
      end
      PH_OPER1: begin
        if (e_hop == OP_LRG_L) begin
          do_begin = 1'b1;
          bl       = {1'b0, byte_q} + LRG_BIAS;
        end else if (e_hop == OP_LRG_M) begin
          do_begin = 1'b1;
          bm       = {1'b0, byte_q} + LRG_BIAS;
        end else if (e_hop[7:5] == TOP_MED_D || e_hop[2:0] == LOW_LRG_D) begin
          n_hoper = byte_q;
          n_phase = PH_OPER2;
        end else begin
          n_dist   = {5'd0, e_hop[2:0], byte_q};
          do_begin = 1'b1;
          bl       = {7'd0, e_hop[7:6]};
          bm       = {6'd0, e_hop[5:3]} + {4'd0, MATCH_MIN};
        end
      end
      PH_OPER2: begin
        do_begin = 1'b1;
        if (e_hop[7:5] == TOP_MED_D) begin
          n_dist = {2'd0, byte_q, e_hoper[7:2]};
          bl     = {7'd0, e_hop[4:3]};
          bm     = {4'd0, e_hop[2:0], e_hoper[1:0]} + {4'd0, MATCH_MIN};
        end else begin
          n_dist = {byte_q, e_hoper};
          bl     = {7'd0, e_hop[7:6]};
          bm     = {6'd0, e_hop[5:3]} + {4'd0, MATCH_MIN};
        end
      end
      PH_LIT: begin
        put    = 1'b1;
        n_lits = (e_lits != '0) ? e_lits - 9'd1 : '0;
        do_run = (n_lits == '0);
      end
      PH_PAD: begin
        n_pad = (e_pad != '0) ? e_pad - 3'd1 : '0;
        if (n_pad == '0) n_phase = PH_HALT;
      end
      default: ;
    endcase
    if (do_begin) begin
      n_lits = bl;
      n_mlen = bm;
      if (bl != '0) n_phase = PH_LIT;
      else do_run = 1'b1;
    end
    bw_after = (put && e_bw < BWW'(WINDOW_DEPTH)) ? e_bw + BWW'(1) : e_bw;
    if (do_run) begin
      n_phase = PH_OPCODE;
      if (n_mlen != '0) begin
        if (n_dist == '0 || {1'b0, n_dist} > 17'(bw_after)) begin
          n_stat  = ST_BAD_DIST;
          n_phase = PH_HALT;
          n_mlen  = '0;
        end else begin
          n_go = 1'b1;
        end
      end
    end
  end

  always_comb begin
    wp18   = 18'(wp);
    d18    = 18'(match_dist);
    src18  = (wp18 >= d18) ? wp18 - d18 : wp18 + 18'(WINDOW_DEPTH) - d18;
    raddr  = src18[AW-1:0];
    wp_inc = (wp == AW'(WINDOW_DEPTH - 1)) ? '0 : wp + AW'(1);
    we     = (cmd.parse && put) || cmd.cp;
    waddr  = cmd.parse ? e_wp : wp;
    wdata  = cmd.parse ? byte_q : rdata;
  end

  always_ff @(posedge clk) begin
    if (we) hist[waddr] <= wdata;
    if (cmd.rd) rdata <= hist[raddr];
  end

  always_comb begin
    packed_bytes = '0;
    for (int i = 0; i < BYTES_PER_RESULT; i++) begin
      if (NW'(i) < cnt) packed_bytes[i*8 +: 8] = pack[i];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      byte_q <= in_byte;
      blk_q  <= new_block;
    end
    if ((cmd.parse && put) || cmd.cp) pack[cnt[CW-1:0]] <= wdata;
    if (cmd.emit_pack) out_bytes <= packed_bytes;
    if (cmd.emit_stat) out_bytes <= '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_OPCODE;
      wp        <= '0;
      bw        <= '0;
      match_dist <= '0;
      hop       <= '0;
      hoper     <= '0;
      lits      <= '0;
      mlen      <= '0;
      pad       <= '0;
      stat_code <= ST_DATA;
      cnt       <= '0;
      out_valid <= 1'b0;
      byte_count <= '0;
      last      <= 1'b0;
      status    <= ST_DATA;
    end else begin
      if (cmd.parse) begin
        phase     <= n_phase;
        wp        <= put ? ((e_wp == AW'(WINDOW_DEPTH - 1)) ? '0 : e_wp + AW'(1)) : e_wp;
        bw        <= bw_after;
        match_dist <= n_dist;
        hop       <= n_hop;
        hoper     <= n_hoper;
        lits      <= n_lits;
        mlen      <= n_mlen;
        pad       <= n_pad;
        stat_code <= n_stat;
        cnt       <= put ? NW'(1) : '0;
      end
      if (cmd.cp) begin
        wp   <= wp_inc;
        bw   <= (bw < BWW'(WINDOW_DEPTH)) ? bw + BWW'(1) : bw;
        mlen <= mlen - 9'd1;
      end
      if (cmd.emit_pack && cmd.rd) cnt <= '0;
      else if (cmd.emit_pack) cnt <= '0;
      else if (cmd.cp) cnt <= cnt + NW'(1);
      if (cmd.emit_pack) begin
        out_valid  <= 1'b1;
        byte_count <= 4'(cnt);
        last       <= cmd.emit_last;
        status     <= ST_DATA;
      end else if (cmd.emit_stat) begin
        out_valid  <= 1'b1;
        byte_count <= '0;
        last       <= 1'b1;
        status     <= stat_code;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign sts.go_match  = n_go;
  assign sts.pack_full = (cnt == NW'(BYTES_PER_RESULT));
  assign sts.pack_nz   = (cnt != '0);
  assign sts.stat_nz   = (stat_code != ST_DATA);
  assign sts.out_free  = !out_valid || out_ready;
  assign sts.match_one = (mlen == 9'd1);

endmodule

// ----- design/lzvn_decoder_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzvn_decoder_top
// LZVN payload decoder, one compressed byte per transaction.
// ----------------------------------------------------------------------------
// usage
//   payload: one compressed byte per transaction, new_block on the first
//     byte of a block restarts the history window, distance and parser state
//   result: packed decoded bytes, little-endian, up to BYTES_PER_RESULT per
//     transaction, last set on the final result caused by one input byte;
//     status results (end of stream, undefined opcode, bad distance) carry
//     no bytes and halt decoding until the next new_block
// timing
//   one byte at a time: a byte is taken in the idle cycle, parsed in the
//   next, then data and status results are flushed; a match adds a read
//   and a write state per copied byte, as the history memory read is
//   registered ahead of its write-back; with no match a data result is
//   registered in the flush state and a status result in the status state
// reset
//   rst clears parser, pointers and output valid; history is not cleared
// stall
//   the output register holds a result until taken; the sequencer waits
//   whenever it has a further result and the register is still full
// ----------------------------------------------------------------------------
module lzvn_decoder_top #(
  parameter int WINDOW_DEPTH     = lzvn_pkg::WindowDepthDefault,
  parameter int BYTES_PER_RESULT = lzvn_pkg::BytesPerResultDefault
) (
  input logic            clk,
  input logic            rst,
  lzvn_payload_if.sink   payload,
  lzvn_result_if.source  result
);
  import lzvn_pkg::*;

  lzvn_cmd_t cmd;
  lzvn_sts_t sts;

  lzvn_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (payload.valid),
    .in_ready (payload.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lzvn_datapath #(
    .WINDOW_DEPTH     (WINDOW_DEPTH),
    .BYTES_PER_RESULT (BYTES_PER_RESULT)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .in_byte     (payload.in_byte),
    .new_block   (payload.new_block),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (result.valid),
    .out_ready   (result.ready),
    .out_bytes   (result.out_bytes),
    .byte_count  (result.byte_count),
    .last        (result.last),
    .status      (result.status)
  );

endmodule

// ----- design/lzvn_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzvn_checker
// Port-level checks on the decoder payload and result channels.
// ----------------------------------------------------------------------------
module lzvn_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] out_bytes,
  input logic [3:0]  byte_count,
  input logic        last,
  input logic [1:0]  status
);
  import lzvn_pkg::*;

  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_bytes) && $stable(status))
    else $error("result changed while stalled");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_DATA |-> byte_count == 4'd0 && last && out_bytes == '0)
    else $error("status result malformed");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_DATA |-> byte_count != 4'd0 && byte_count <= 4'd8)
    else $error("data result byte count out of range");

  assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("byte taken on consecutive cycles");

endmodule

bind lzvn_decoder_top lzvn_checker u_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (payload.valid),
  .in_ready   (payload.ready),
  .out_valid  (result.valid),
  .out_ready  (result.ready),
  .out_bytes  (result.out_bytes),
  .byte_count (result.byte_count),
  .last       (result.last),
  .status     (result.status)
);
